### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, quiet while arst_n is low
`define WAMT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same check, but also evaluated during reset
`define WAMT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/wamt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wamt_pkg;

	localparam int ENTRIES     = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	localparam logic ST_OK        = 1'b0;
	localparam logic ST_BAD_INDEX = 1'b1;

	typedef struct packed {
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [6:0]  week_mask;
		logic [30:0] month_mask;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

endpackage

`default_nettype wire

### rtl/wamt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wamt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [5:0]  entry_index;
	logic [4:0]  sched_hour;
	logic [5:0]  sched_minute;
	logic [6:0]  sched_week_mask;
	logic [30:0] sched_month_mask;
	logic [4:0]  now_hour;
	logic [5:0]  now_minute;
	logic [2:0]  now_weekday;
	logic [4:0]  now_month_day;

	modport source (
		output valid, operation, entry_index, sched_hour, sched_minute,
		       sched_week_mask, sched_month_mask, now_hour, now_minute,
		       now_weekday, now_month_day,
		input  ready
	);
	modport sink (
		input  valid, operation, entry_index, sched_hour, sched_minute,
		       sched_week_mask, sched_month_mask, now_hour, now_minute,
		       now_weekday, now_month_day,
		output ready
	);
endinterface

interface wamt_rsp_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic       fired;
	logic [5:0] fired_index;
	logic       last_result;

	modport source (
		output valid, status, fired, fired_index, last_result,
		input  ready
	);
	modport sink (
		input  valid, status, fired, fired_index, last_result,
		output ready
	);
endinterface

`default_nettype wire

### rtl/wamt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module wamt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/wamt_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module wamt_scan import wamt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	wamt_req_if.sink   req,
	wamt_rsp_if.source rsp,
	output ram_req_t   ram,
	input  wire entry_t ram_rdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FLUSH
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] scan_q;
	logic             issue_done_q;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [ENTRIES-1:0] active_q;
	logic [ENTRIES-1:0] latch_q;
	logic             pend_vq;
	logic [IDX_W-1:0] pend_idx_q;
	logic [CNT_W-1:0] n_q;
	logic [4:0]       now_hour_q;
	logic [5:0]       now_minute_q;
	logic [2:0]       now_weekday_q;
	logic [4:0]       now_month_day_q;
	logic             out_vq;
	logic             out_status_q;
	logic             out_fired_q;
	logic [5:0]       out_idx_q;
	logic             out_last_q;

	logic       out_free;
	logic       req_fire;
	logic       bad_idx;
	logic [7:0] wk_vec;
	logic [31:0] mo_vec;
	logic       hit;
	logic       stall;
	logic       issue;
	logic       out_load;

	assign out_free  = !out_vq || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign req_fire  = req.valid && req.ready;
	assign bad_idx   = {1'b0, req.entry_index} >= 7'(ENTRIES);

	// bit 0 pads so weekday 0 and month day 0 never match
	assign wk_vec = {ram_rdata.week_mask, 1'b0};
	assign mo_vec = {ram_rdata.month_mask, 1'b0};

	assign hit = valid_s1 && active_q[idx_s1] && !latch_q[idx_s1]
		&& (ram_rdata.hour == now_hour_q) && (ram_rdata.minute == now_minute_q)
		&& (wk_vec[now_weekday_q] || mo_vec[now_month_day_q])
		&& (n_q < CNT_W'(MAX_RESULTS));

	// a new hit pushes the held one out, which needs the output register
	assign stall = hit && pend_vq && !out_free;
	assign issue = (state_q == S_SCAN) && !issue_done_q && !stall;

	// result register takes a new beat this cycle
	assign out_load = (req_fire && (req.operation != OP_TICK))
		|| ((state_q == S_SCAN) && hit && !stall && pend_vq)
		|| ((state_q == S_FLUSH) && out_free);

	assign ram.we               = req_fire && (req.operation == OP_ADD) && !bad_idx;
	assign ram.waddr            = req.entry_index[IDX_W-1:0];
	assign ram.wdata.hour       = req.sched_hour;
	assign ram.wdata.minute     = req.sched_minute;
	assign ram.wdata.week_mask  = req.sched_week_mask;
	assign ram.wdata.month_mask = req.sched_month_mask;
	assign ram.re               = issue;
	assign ram.raddr            = scan_q;

	assign rsp.valid       = out_vq;
	assign rsp.status      = out_status_q;
	assign rsp.fired       = out_fired_q;
	assign rsp.fired_index = out_idx_q;
	assign rsp.last_result = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			scan_q          <= '0;
			issue_done_q    <= 1'b0;
			valid_s1        <= 1'b0;
			idx_s1          <= '0;
			active_q        <= '0;
			latch_q         <= '0;
			pend_vq         <= 1'b0;
			pend_idx_q      <= '0;
			n_q             <= '0;
			now_hour_q      <= '0;
			now_minute_q    <= '0;
			now_weekday_q   <= '0;
			now_month_day_q <= '0;
			out_vq          <= 1'b0;
			out_status_q    <= ST_OK;
			out_fired_q     <= 1'b0;
			out_idx_q       <= '0;
			out_last_q      <= 1'b0;
		end else begin
			if (rsp.ready && !out_load) begin
				out_vq <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						unique case (req.operation) inside
							OP_ADD, OP_REMOVE: begin
								out_vq       <= 1'b1;
								out_fired_q  <= 1'b0;
								out_idx_q    <= '0;
								out_last_q   <= 1'b1;
								if (bad_idx) begin
									out_status_q <= ST_BAD_INDEX;
								end else begin
									out_status_q <= ST_OK;
									active_q[req.entry_index[IDX_W-1:0]] <=
										(req.operation == OP_ADD);
									latch_q[req.entry_index[IDX_W-1:0]] <= 1'b0;
								end
							end
							OP_TICK: begin
								now_hour_q      <= req.now_hour;
								now_minute_q    <= req.now_minute;
								now_weekday_q   <= req.now_weekday;
								now_month_day_q <= req.now_month_day;
								scan_q          <= '0;
								issue_done_q    <= 1'b0;
								n_q             <= '0;
								state_q         <= S_SCAN;
							end
							default: begin
								out_vq       <= 1'b1;
								out_status_q <= ST_OK;
								out_fired_q  <= 1'b0;
								out_idx_q    <= '0;
								out_last_q   <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (!stall) begin
						valid_s1 <= issue;
						idx_s1   <= scan_q;
					end
					if (issue) begin
						scan_q <= scan_q + 1'b1;
						if (scan_q == IDX_W'(ENTRIES - 1)) begin
							issue_done_q <= 1'b1;
						end
					end
					if (hit && !stall) begin
						latch_q[idx_s1] <= 1'b1;
						n_q             <= n_q + 1'b1;
						pend_vq         <= 1'b1;
						pend_idx_q      <= idx_s1;
						if (pend_vq) begin
							out_vq       <= 1'b1;
							out_status_q <= ST_OK;
							out_fired_q  <= 1'b1;
							out_idx_q    <= 6'(pend_idx_q);
							out_last_q   <= 1'b0;
						end
					end
					if (issue_done_q && !valid_s1) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						out_vq       <= 1'b1;
						out_status_q <= ST_OK;
						out_fired_q  <= pend_vq;
						out_idx_q    <= pend_vq ? 6'(pend_idx_q) : 6'd0;
						out_last_q   <= 1'b1;
						pend_vq      <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/weekly_alarm_match_table.sv
// Weekly alarm match table.
// req channel: one beat per operation. Add writes an entry (hour, minute,
// weekday mask, month-day mask) and arms it with its fired latch clear;
// remove disarms it; tick carries the current time and scans the table.
// rsp channel: add, remove and unknown operations give one beat in the cycle
// after acceptance; status is set for an add or remove with entry_index out of range.
// A tick gives one beat per entry that fires, in index order, the final one
// flagged by last_result, or a single non-firing beat when nothing fires.
// Scan: a tick holds the block until its final beat is loaded. The entry memory has
// one read port and the scan reads one entry per cycle while no stall holds it,
// then waits for the last read data, sees the pipe empty and sends the final
// beat from the flush state.
// No new req beat is taken during a scan.
// Reset clears all active flags and fired latches at once; no memory sweep.
// When rsp stalls the result register holds its beat; the scan keeps one
// firing entry in hand and pauses only when a second one finds the register
// still full.
`timescale 1ns / 1ps
`default_nettype none

module weekly_alarm_match_table import wamt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	wamt_req_if.sink   req,
	wamt_rsp_if.source rsp
);

	ram_req_t ram_req;
	entry_t   ram_rdata;

	wamt_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	wamt_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.ram       (ram_req),
		.ram_rdata (ram_rdata)
	);

endmodule

`default_nettype wire

### rtl/wamt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wamt_checker import wamt_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic [1:0] req_operation,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic       rsp_status,
	input wire logic       rsp_fired,
	input wire logic [5:0] rsp_fired_index,
	input wire logic       rsp_last_result
);

	`WAMT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fired_index) && $stable(rsp_fired) && $stable(rsp_last_result), "rsp beat changed while stalled")
	`WAMT_ASSERT(a_idle_index_zero, rsp_valid && !rsp_fired |-> rsp_fired_index == 6'd0, "non-firing beat with nonzero index")
	`WAMT_ASSERT(a_bad_index_beat, rsp_valid && rsp_status |-> !rsp_fired && rsp_last_result, "bad index beat must be a single non-firing beat")
	`WAMT_ASSERT(a_index_range, rsp_valid && rsp_fired |-> {1'b0, rsp_fired_index} < 7'(ENTRIES), "fired index beyond table")
	`WAMT_ASSERT(a_tick_busy, req_valid && req_ready && req_operation == OP_TICK |=> !req_ready, "req taken right after a tick")

endmodule

bind weekly_alarm_match_table wamt_checker u_wamt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_operation   (req.operation),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_fired       (rsp.fired),
	.rsp_fired_index (rsp.fired_index),
	.rsp_last_result (rsp.last_result)
);

`default_nettype wire

### bench/tb_weekly_alarm_match_table.sv
`timescale 1ns / 1ps

module tb_weekly_alarm_match_table;
	import wamt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [1:0]  operation;
		logic [5:0]  entry_index;
		logic [4:0]  sched_hour;
		logic [5:0]  sched_minute;
		logic [6:0]  sched_week_mask;
		logic [30:0] sched_month_mask;
		logic [4:0]  now_hour;
		logic [5:0]  now_minute;
		logic [2:0]  now_weekday;
		logic [4:0]  now_month_day;
	} alarm_req_t;

	typedef struct packed {
		logic       status;
		logic       fired;
		logic [5:0] fired_index;
		logic       last_result;
	} alarm_rsp_t;

	logic clk = 1'b0;
	logic arst_n;
	logic rsp_ready = 1'b0;

	wamt_req_if req_ch ();
	wamt_rsp_if rsp_ch ();

	assign rsp_ch.ready = rsp_ready;

	weekly_alarm_match_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #10 clk = ~clk;

	// shadow copy of the alarm table
	logic       slot_active [ENTRIES];
	logic       slot_latch  [ENTRIES];
	entry_t     slot_entry  [ENTRIES];
	alarm_rsp_t expected_beats [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches    = 0;
	int cycle_count   = 0;
	int req_count     = 0;
	int tick_count    = 0;
	int bad_idx_count = 0;
	int fire_count    = 0;
	int most_fires    = 0;

	function automatic alarm_rsp_t make_rsp(input logic st, input logic fi,
	                                        input logic [5:0] idx, input logic last);
		alarm_rsp_t r;
		r.status      = st;
		r.fired       = fi;
		r.fired_index = idx;
		r.last_result = last;
		return r;
	endfunction

	function automatic void predict_alarm_results(input alarm_req_t b);
		int         n;
		logic       wk;
		logic       mo;
		alarm_rsp_t r;
		n = 0;
		req_count++;
		case (b.operation) inside
			OP_ADD, OP_REMOVE: begin
				if (b.entry_index >= ENTRIES) begin
					bad_idx_count++;
					expected_beats.push_back(make_rsp(ST_BAD_INDEX, 1'b0, 6'd0, 1'b1));
				end else begin
					slot_active[b.entry_index] = (b.operation == OP_ADD);
					slot_latch[b.entry_index]  = 1'b0;
					if (b.operation == OP_ADD) begin
						slot_entry[b.entry_index].hour       = b.sched_hour;
						slot_entry[b.entry_index].minute     = b.sched_minute;
						slot_entry[b.entry_index].week_mask  = b.sched_week_mask;
						slot_entry[b.entry_index].month_mask = b.sched_month_mask;
					end else begin
						slot_entry[b.entry_index] = '0;
					end
					expected_beats.push_back(make_rsp(ST_OK, 1'b0, 6'd0, 1'b1));
				end
			end
			OP_TICK: begin
				tick_count++;
				for (int i = 0; i < ENTRIES && n < MAX_RESULTS; i++) begin
					// weekday 0 and month day 0 select no mask bit
					wk = (b.now_weekday != 0) && slot_entry[i].week_mask[b.now_weekday - 1];
					mo = (b.now_month_day != 0) &&
					     slot_entry[i].month_mask[b.now_month_day - 1];
					if (slot_active[i] && !slot_latch[i] &&
					    slot_entry[i].hour == b.now_hour &&
					    slot_entry[i].minute == b.now_minute && (wk || mo)) begin
						slot_latch[i] = 1'b1;
						expected_beats.push_back(make_rsp(ST_OK, 1'b1, 6'(i), 1'b0));
						n++;
					end
				end
				if (n == 0) begin
					expected_beats.push_back(make_rsp(ST_OK, 1'b0, 6'd0, 1'b1));
				end else begin
					r = expected_beats.pop_back();
					r.last_result = 1'b1;
					expected_beats.push_back(r);
				end
				fire_count += n;
				if (n > most_fires)
					most_fires = n;
			end
			default: begin
				expected_beats.push_back(make_rsp(ST_OK, 1'b0, 6'd0, 1'b1));
			end
		endcase
	endfunction

	function automatic alarm_req_t random_req();
		alarm_req_t b;
		b.operation        = 2'($urandom);
		b.entry_index      = 6'($urandom);
		b.sched_hour       = 5'($urandom);
		b.sched_minute     = 6'($urandom);
		b.sched_week_mask  = 7'($urandom);
		b.sched_month_mask = 31'($urandom);
		b.now_hour         = 5'($urandom);
		b.now_minute       = 6'($urandom);
		b.now_weekday      = 3'($urandom);
		b.now_month_day    = 5'($urandom);
		return b;
	endfunction

	function automatic void check_field(input string name, input logic [5:0] want,
	                                    input logic [5:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// result checker and receiver stalls
	always @(posedge clk) begin
		alarm_rsp_t got;
		alarm_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ready) begin
			got = make_rsp(rsp_ch.status, rsp_ch.fired, rsp_ch.fired_index,
			               rsp_ch.last_result);
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, actual %h", $time, got);
				mismatches++;
			end else begin
				want = expected_beats.pop_front();
				check_field("status", 6'(want.status), 6'(got.status));
				check_field("fired", 6'(want.fired), 6'(got.fired));
				check_field("fired_index", want.fired_index, got.fired_index);
				check_field("last_result", 6'(want.last_result), 6'(got.last_result));
			end
		end
		rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d result beats outstanding", $time,
			         expected_beats.size());
			$display("tb_weekly_alarm_match_table: FAIL");
			$finish;
		end
	end

	task automatic send_req(input alarm_req_t b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid            <= 1'b1;
		req_ch.operation        <= b.operation;
		req_ch.entry_index      <= b.entry_index;
		req_ch.sched_hour       <= b.sched_hour;
		req_ch.sched_minute     <= b.sched_minute;
		req_ch.sched_week_mask  <= b.sched_week_mask;
		req_ch.sched_month_mask <= b.sched_month_mask;
		req_ch.now_hour         <= b.now_hour;
		req_ch.now_minute       <= b.now_minute;
		req_ch.now_weekday      <= b.now_weekday;
		req_ch.now_month_day    <= b.now_month_day;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predict_alarm_results(b);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_beats.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_table();
		alarm_req_t b;
		b = random_req();
		b.operation     = OP_TICK;
		b.now_hour      = '0;
		b.now_minute    = '0;
		b.now_weekday   = 3'd1;
		b.now_month_day = 5'd1;
		send_req(b);
	endtask

	task automatic test_bad_index();
		alarm_req_t b;
		b = random_req();
		b.operation        = OP_ADD;
		b.entry_index      = 6'(ENTRIES);
		b.sched_hour       = '1;
		b.sched_minute     = '1;
		b.sched_week_mask  = '1;
		b.sched_month_mask = '1;
		send_req(b);
		b.operation   = OP_REMOVE;
		b.entry_index = '1;
		send_req(b);
	endtask

	task automatic test_unknown_operation();
		alarm_req_t b;
		b = random_req();
		b.operation = 2'd3;
		send_req(b);
	endtask

	task automatic test_full_table();
		alarm_req_t b;
		for (int i = 0; i < ENTRIES; i++) begin
			b = random_req();
			b.operation        = OP_ADD;
			b.entry_index      = 6'(i);
			b.sched_hour       = 5'd23;
			b.sched_minute     = 6'd59;
			b.sched_week_mask  = 7'(i * 9);
			b.sched_month_mask = '1;
			send_req(b);
		end
		// every slot fires, then the latches keep the repeat tick quiet
		b = random_req();
		b.operation     = OP_TICK;
		b.now_hour      = 5'd23;
		b.now_minute    = 6'd59;
		b.now_weekday   = 3'd7;
		b.now_month_day = 5'd31;
		send_req(b);
		send_req(b);
	endtask

	task automatic test_weekday_edges();
		alarm_req_t b;
		b = random_req();
		b.operation   = OP_REMOVE;
		b.entry_index = 6'd3;
		send_req(b);
		b = random_req();
		b.operation        = OP_ADD;
		b.entry_index      = 6'd5;
		b.sched_hour       = '1;
		b.sched_minute     = '1;
		b.sched_week_mask  = '1;
		b.sched_month_mask = '0;
		send_req(b);
		b = random_req();
		b.operation     = OP_TICK;
		b.now_hour      = '1;
		b.now_minute    = '1;
		b.now_weekday   = 3'd0;
		b.now_month_day = 5'd0;
		send_req(b);
		b.now_weekday = 3'd7;
		send_req(b);
	endtask

	task automatic test_random_traffic(input int count);
		alarm_req_t b;
		int         pick;
		int         s;
		for (int k = 0; k < count; k++) begin
			b    = random_req();
			pick = $urandom_range(0, 99);
			// few distinct times so that entries share a minute and fire together
			if (pick < 40) begin
				b.operation    = OP_ADD;
				b.entry_index  = 6'($urandom_range(0, ENTRIES - 1));
				b.sched_hour   = $urandom_range(0, 1) ? 5'd9 : 5'd23;
				b.sched_minute = $urandom_range(0, 1) ? 6'd0 : 6'd45;
				if ($urandom_range(0, 3) == 0)
					b.sched_month_mask = '0;
			end else if (pick < 52) begin
				b.operation   = OP_REMOVE;
				b.entry_index = 6'($urandom_range(0, ENTRIES - 1));
			end else if (pick < 90) begin
				s = $urandom_range(0, ENTRIES - 1);
				b.operation     = OP_TICK;
				b.now_hour      = slot_entry[s].hour;
				b.now_minute    = slot_entry[s].minute;
				b.now_weekday   = 3'($urandom_range(1, 7));
				b.now_month_day = 5'($urandom_range(1, 31));
			end
			send_req(b);
		end
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			slot_active[i] = 1'b0;
			slot_latch[i]  = 1'b0;
			slot_entry[i]  = '0;
		end
		arst_n                  <= 1'b0;
		req_ch.valid            <= 1'b0;
		req_ch.operation        <= OP_ADD;
		req_ch.entry_index      <= '0;
		req_ch.sched_hour       <= '0;
		req_ch.sched_minute     <= '0;
		req_ch.sched_week_mask  <= '0;
		req_ch.sched_month_mask <= '0;
		req_ch.now_hour         <= '0;
		req_ch.now_minute       <= '0;
		req_ch.now_weekday      <= '0;
		req_ch.now_month_day    <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 15;
		recv_idle_pct = 55;
		test_empty_table();
		test_bad_index();
		test_unknown_operation();
		test_full_table();
		test_weekday_edges();
		test_random_traffic(25);
		wait_drained();

		send_idle_pct = 55;
		recv_idle_pct = 15;
		test_random_traffic(25);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(25);
		wait_drained();
		repeat (ENTRIES + 8) @(posedge clk);

		$display("run covered %0d request beats: %0d ticks, %0d bad index",
		         req_count, tick_count, bad_idx_count);
		$display("%0d entries fired, at most %0d on one tick", fire_count, most_fires);
		if (mismatches == 0 && expected_beats.size() == 0) begin
			$display("tb_weekly_alarm_match_table: PASS");
		end else begin
			$display("tb_weekly_alarm_match_table: FAIL");
		end
		$finish;
	end

endmodule

### weekly_alarm_match_table.f
+incdir+rtl
rtl/wamt_pkg.sv
rtl/wamt_if.sv
rtl/wamt_ram.sv
rtl/wamt_scan.sv
rtl/weekly_alarm_match_table.sv
rtl/wamt_checker.sv
bench/tb_weekly_alarm_match_table.sv
